[src/jks_pkg.sv]
// Shared definitions for the Jacobi/Kronecker symbol block.
// Holds the sequencer state type, the operand port width and the (2/n) sign table.
// No dependencies.
`default_nettype none

package jks_pkg;

    // Operand ports carry full 64-bit words; only the low WIDTH bits are used.
    localparam int OPERAND_W = 64;

    // Encoded symbol values.
    localparam logic signed [1:0] SYM_ZERO = 2'sb00;
    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;

    // (2/n) for odd n, indexed by n mod 8. Entries for even n are never read.
    localparam logic signed [1:0] TWO_SIGN_TAB [8] = '{
        SYM_ZERO, SYM_POS, SYM_ZERO, SYM_NEG, SYM_ZERO, SYM_NEG, SYM_ZERO, SYM_POS
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIP_B,
        ST_TEST_A,
        ST_STRIP_A,
        ST_MOD
    } jks_state_t;

endpackage

`default_nettype wire

[src/jks_rem_unit.sv]
// Bit-serial restoring remainder unit: dividend mod divisor, one quotient bit per cycle.
// Standalone; the divisor must hold steady from start until done.
`default_nettype none

module jks_rem_unit #(
    parameter int WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      remainder
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // Shift the next dividend bit into the partial remainder and subtract when it fits.
    assign trial = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            dvd_next = dividend;
            cnt_next = CNT_LAST;
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[src/jacobi_kronecker_symbol.sv]
// Top level of the Jacobi/Kronecker symbol block: sequencer, operand registers and result.
// Depends on jks_pkg and jks_rem_unit.
`default_nettype none

//  Channel   | Ports                          | Handshake
//  ----------+--------------------------------+-------------------------------------------
//  command   | start, operand_a, operand_b    | beat taken at an edge with start & !busy
//  result    | done, symbol                   | one-cycle strobe on done, cannot be stalled
//
// An item with a zero denominator, or with both operands even, is answered at once: the
// result strobe comes the cycle after the command beat and busy never rises. Otherwise busy
// stays high while the sequencer strips twos from b and then runs the Euclid rounds, each
// stripping twos from a in the one-bit-per-cycle shifter and taking b mod a in the bit-serial
// remainder unit; the result strobe comes in the cycle busy falls. Reset is asynchronous
// and returns the sequencer to idle with no result pending. The result side cannot stall;
// a new command may be given in the same cycle a result is strobed.

module jacobi_kronecker_symbol
    import jks_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OPERAND_W-1:0] operand_a,
    input  wire logic [OPERAND_W-1:0] operand_b,
    output logic                      done,
    output logic signed [1:0]         symbol
);

    jks_state_t        state_reg, state_next;
    logic [WIDTH-1:0]  a_reg, a_next;
    logic [WIDTH-1:0]  b_reg, b_next;
    logic              neg_reg, neg_next;   // running sign is -1 when set
    logic              par_reg, par_next;   // parity of the twos stripped so far
    logic              done_reg, done_next;
    logic signed [1:0] sym_reg, sym_next;

    logic [WIDTH-1:0]  in_a;
    logic [WIDTH-1:0]  in_b;
    logic              rem_start;
    logic              rem_done;
    logic [WIDTH-1:0]  rem_value;
    logic              two_neg_a;
    logic              two_neg_b;

    assign in_a = operand_a[WIDTH-1:0];
    assign in_b = operand_b[WIDTH-1:0];

    // (2/a) and (2/b) sign lookups on the low three bits.
    assign two_neg_a = (TWO_SIGN_TAB[a_reg[2:0]] == SYM_NEG);
    assign two_neg_b = (TWO_SIGN_TAB[b_reg[2:0]] == SYM_NEG);

    // The shared remainder unit computes b mod a for every Euclid round.
    jks_rem_unit #(
        .WIDTH (WIDTH)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (b_reg),
        .divisor   (a_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        par_next   = par_reg;
        done_next  = 1'b0;
        sym_next   = sym_reg;
        rem_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    a_next   = in_a;
                    b_next   = in_b;
                    neg_next = 1'b0;
                    par_next = 1'b0;
                    if (in_b == '0) begin
                        // Zero denominator: the symbol is one only for a equal to one.
                        done_next = 1'b1;
                        sym_next  = (in_a == WIDTH'(1)) ? SYM_POS : SYM_ZERO;
                    end else if (!in_a[0] && !in_b[0]) begin
                        done_next = 1'b1;
                        sym_next  = SYM_ZERO;
                    end else begin
                        state_next = ST_STRIP_B;
                    end
                end
            end

            ST_STRIP_B: begin
                if (!b_reg[0]) begin
                    b_next   = {1'b0, b_reg[WIDTH-1:1]};
                    par_next = !par_reg;
                end else begin
                    // An odd count of twos in b takes the (2/a) sign; a is odd then.
                    neg_next   = par_reg & two_neg_a;
                    par_next   = 1'b0;
                    state_next = ST_TEST_A;
                end
            end

            ST_TEST_A: begin
                if (a_reg == '0) begin
                    // A common factor above one makes the symbol zero.
                    done_next  = 1'b1;
                    sym_next   = (b_reg[WIDTH-1:1] != '0) ? SYM_ZERO
                               : (neg_reg ? SYM_NEG : SYM_POS);
                    state_next = ST_IDLE;
                end else begin
                    par_next   = 1'b0;
                    state_next = ST_STRIP_A;
                end
            end

            ST_STRIP_A: begin
                if (!a_reg[0]) begin
                    a_next   = {1'b0, a_reg[WIDTH-1:1]};
                    par_next = !par_reg;
                end else begin
                    // Apply (2/b) for an odd count, then reciprocity when both are 3 mod 4.
                    neg_next   = neg_reg ^ (par_reg & two_neg_b) ^ (a_reg[1] & b_reg[1]);
                    rem_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end

            ST_MOD: begin
                if (rem_done) begin
                    b_next     = a_reg;
                    a_next     = rem_value;
                    state_next = ST_TEST_A;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        par_reg <= par_next;
        sym_reg <= sym_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign symbol = sym_reg;

    // Leaving the busy phase always delivers exactly the result of that item.
    a_busy_end_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n) $fell(busy) |-> done
    ) else $error("busy fell without a result strobe");

    // An accepted command either finishes at once or keeps the block busy.
    a_accept_progress: assert property (
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done)
    ) else $error("accepted command neither answered nor in progress");

    // The remainder unit reports only while the sequencer waits on it.
    a_rem_done_in_mod: assert property (
        @(posedge clk) disable iff (!rst_n) rem_done |-> (state_reg == ST_MOD)
    ) else $error("remainder finished outside the modulo phase");

    // The unused code of the symbol never appears on a result.
    a_symbol_code: assert property (
        @(posedge clk) disable iff (!rst_n) done |-> (symbol != 2'sb10)
    ) else $error("invalid symbol code on result");

endmodule

`default_nettype wire

[sim/jacobi_kronecker_symbol_tb.sv]
// Self-checking testbench for jacobi_kronecker_symbol: directed corner cases, then random operand pairs.
// Predicts each symbol in place and compares it with every result strobe.
// Depends on jks_pkg and the jacobi_kronecker_symbol RTL.

module jacobi_kronecker_symbol_tb
    import jks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default operand width.
    localparam int DUT_W = 64;

    // Longest quiet stretch allowed with no command beat and no result. A worst-case
    // 64-bit pair needs about 95 Euclid rounds, so this leaves a wide margin over the
    // slowest correct item plus the longest sender gap.
    localparam int STALL_LIMIT = 40000;

    // Trivial items answer in the cycle after the command beat, so a short tail is enough
    // to catch a stray strobe after the last expected result.
    localparam int TAIL_CYCLES = 32;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] TOP_BIT  = {1'b1, 63'd0};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [OPERAND_W-1:0] operand_a = '0;
    logic [OPERAND_W-1:0] operand_b = '0;
    wire                  busy;
    wire                  done;
    wire signed [1:0]     symbol;

    // One outstanding command: its operands are kept for the mismatch report.
    typedef struct packed {
        logic [63:0]       a;
        logic [63:0]       b;
        logic signed [1:0] sym;
    } symbol_entry_t;

    symbol_entry_t expected_symbols[$];

    int unsigned error_count  = 0;
    int unsigned pairs_sent   = 0;
    int unsigned checked_zero = 0;
    int unsigned checked_pos  = 0;
    int unsigned checked_neg  = 0;
    int unsigned quiet_cycles = 0;

    // When set, the sender puts commands back to back with no gap at all.
    bit burst_mode = 1'b0;

    jacobi_kronecker_symbol #(
        .WIDTH(DUT_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .done     (done),
        .symbol   (symbol)
    );

    // 12 ns clock, low half first, so the first rising edge is at 6 ns.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // (2/n) for odd n depends only on n mod 8: +1 for 1 and 7, -1 for 3 and 5.
    // Even residues never matter, since the caller only asks about odd values or
    // about a case where the zero propagates into a both-even answer.
    function automatic int two_factor(input logic [2:0] n_mod8);
        case (n_mod8)
            3'd1, 3'd7: return 1;
            3'd3, 3'd5: return -1;
            default:    return 0;
        endcase
    endfunction

    // Computes the Kronecker symbol (a/b) with the binary Euclid scheme: the sign
    // collects the (2/.) factors of stripped twos and the reciprocity flips, and the
    // answer collapses to zero when the final gcd is above one.
    function automatic logic signed [1:0] predict_symbol(input logic [63:0] a_raw,
                                                         input logic [63:0] b_raw);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] rem;
        int          sgn;
        int unsigned twos;

        mask = ALL_ONES >> (64 - DUT_W);
        a    = a_raw & mask;
        b    = b_raw & mask;
        sgn  = 1;

        if (b == 64'd0)
            return (a == 64'd1) ? SYM_POS : SYM_ZERO;
        if (!a[0] && !b[0])
            return SYM_ZERO;

        twos = 0;
        while (!b[0])
        begin
            b = b >> 1;
            twos++;
        end
        if (twos[0])
            sgn = two_factor(a[2:0]);

        while (a != 64'd0)
        begin
            twos = 0;
            while (!a[0])
            begin
                a = a >> 1;
                twos++;
            end
            if (twos[0])
                sgn = sgn * two_factor(b[2:0]);
            // Quadratic reciprocity: both odd values are 3 mod 4.
            if (a[1] && b[1])
                sgn = -sgn;
            rem = b % a;
            b   = a;
            a   = rem;
        end

        if (b > 64'd1)
            return SYM_ZERO;
        if (sgn > 0)
            return SYM_POS;
        if (sgn < 0)
            return SYM_NEG;
        return SYM_ZERO;
    endfunction

    // Sends one command beat. The caller is always aligned to a rising edge. A random
    // gap comes first; the gap is counted from the previous beat, so it lands on
    // whatever phase of the previous item the block is in. Start is left high
    // afterwards, so a zero gap on the next call keeps it high without a glitch.
    task automatic send_item(input logic [63:0] a, input logic [63:0] b);
        int unsigned gap;

        gap = burst_mode ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        // The beat is taken at the first edge that sees busy low.
        do
            @(posedge clk);
        while (busy);
        expected_symbols.push_back('{a: a, b: b, sym: predict_symbol(a, b)});
        pairs_sent++;
    endtask

    // Random value of the given bit length, with the top bit of that length set half
    // the time so the magnitude really reaches it.
    function automatic logic [63:0] rand_bits(input int unsigned nbits);
        logic [63:0] v;

        v = {$urandom, $urandom};
        if (nbits < 64)
            v = v & ((64'd1 << nbits) - 64'd1);
        if ($urandom_range(0, 1) == 1)
            v[nbits-1] = 1'b1;
        return v;
    endfunction

    // Most operands are short, since the Euclid round count and so the run time
    // grow with the magnitude; a tenth of them use 49 to 64 bits.
    function automatic int unsigned pick_length();
        int unsigned r;

        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 16);
        if (r < 9)
            return $urandom_range(17, 48);
        return $urandom_range(49, 64);
    endfunction

    // A zero denominator short-circuits: only a = 1 gives +1.
    task automatic test_zero_denominator();
        send_item(64'd1, 64'd0);
        send_item(64'd0, 64'd0);
        send_item(64'd2, 64'd0);
        send_item(ALL_ONES, 64'd0);
    endtask

    // Two even operands share a factor of two, so the symbol is zero at once.
    task automatic test_both_even();
        send_item(64'd2, 64'd4);
        send_item(64'd0, 64'd2);
        send_item(ALL_ONES - 64'd1, TOP_BIT);
    endtask

    // An even denominator pulls in (2/a); walk a through every odd residue mod 8.
    task automatic test_even_denominator();
        send_item(64'd1, 64'd2);
        send_item(64'd3, 64'd2);
        send_item(64'd5, 64'd2);
        send_item(64'd7, 64'd2);
        send_item(64'd3, 64'd8);
    endtask

    // Pairs that exercise the reciprocity flip and the (2/b) factor inside the loop.
    task automatic test_reciprocity();
        send_item(64'd3, 64'd7);
        send_item(64'd7, 64'd3);
        send_item(64'd2, 64'd7);
        send_item(64'd5, 64'd3);
    endtask

    // A gcd above one ends the loop with b > 1, giving zero; a = 0 over b = 1 gives +1.
    task automatic test_common_factor();
        send_item(64'd3, 64'd9);
        send_item(64'd15, 64'd21);
        send_item(64'd0, 64'd1);
    endtask

    // Field extremes in both positions.
    task automatic test_extremes();
        send_item(ALL_ONES, ALL_ONES);
        send_item(ALL_ONES, ALL_ONES - 64'd1);
        send_item(64'd1, ALL_ONES);
        send_item(ALL_ONES, 64'd1);
        send_item(TOP_BIT, ALL_ONES);
        send_item(64'd0, ALL_ONES);
    endtask

    // Random pairs. Most are independent operands of mixed length; the rest are
    // steered into the short-circuit cases, shared odd factors and full-width extremes.
    // Every 40 items the sender may switch into a back-to-back stretch.
    task automatic test_random_pairs(input int unsigned count);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] k;
        int unsigned kind;

        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 19);
            case (kind)
                0:
                begin
                    a = ($urandom_range(0, 1) == 1) ? 64'd1 : rand_bits(pick_length());
                    b = 64'd0;
                end
                1:
                begin
                    a = rand_bits(pick_length()) & ~64'd1;
                    b = rand_bits(pick_length()) & ~64'd1;
                end
                2, 3:
                begin
                    k = 64'($urandom_range(1, 127)) * 64'd2 + 64'd1;
                    a = rand_bits($urandom_range(1, 40)) * k;
                    b = rand_bits($urandom_range(1, 40)) * k;
                end
                4:
                begin
                    a = ($urandom_range(0, 1) == 1) ? ALL_ONES : rand_bits(64);
                    b = ($urandom_range(0, 1) == 1) ? ALL_ONES - 64'(2 * $urandom_range(0, 3))
                                                    : rand_bits(64);
                end
                default:
                begin
                    a = rand_bits(pick_length());
                    b = rand_bits(pick_length());
                end
            endcase
            send_item(a, b);
        end
        burst_mode = 1'b0;
    endtask

    // Result checker and watchdog. Both read signals in the active region of the rising
    // edge, so they see the values that were stable during the cycle that just ended.
    always @(posedge clk)
    begin
        symbol_entry_t exp_entry;

        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat and no result for %0d cycles, %0d results still due",
                         $time, STALL_LIMIT, expected_symbols.size());
                $display("RESULT: ERROR");
                $finish;
            end

            if (done)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: result strobe with nothing outstanding, symbol=%0d",
                             $time, symbol);
                    error_count++;
                end
                else
                begin
                    exp_entry = expected_symbols.pop_front();
                    if (symbol !== exp_entry.sym)
                    begin
                        $display("%0t: symbol mismatch for a=%h b=%h: expected %0d, got %0d",
                                 $time, exp_entry.a, exp_entry.b, exp_entry.sym, symbol);
                        error_count++;
                    end
                    case (exp_entry.sym)
                        SYM_POS: checked_pos++;
                        SYM_NEG: checked_neg++;
                        default: checked_zero++;
                    endcase
                end
            end
        end
    end

    // Test sequence: reset once, the directed corners, then the random bulk, then drain.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_denominator();
        test_both_even();
        test_even_denominator();
        test_reciprocity();
        test_common_factor();
        test_extremes();
        test_random_pairs(675);

        start <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d operand pairs; checked %0d zero, %0d +1 and %0d -1 symbols.",
                 pairs_sent, checked_zero, checked_pos, checked_neg);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
